// File: design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the attitude rotation error p controller
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int Q15W = 17;  // quaternion component at 15 fraction bits
    localparam int PW   = 34;  // product of two components
    localparam int TW   = 36;  // matrix entry at 30 fraction bits
    localparam int MW   = 19;  // matrix entry at 15 fraction bits
    localparam int EPW  = 2 * MW;
    localparam int EW   = 40;  // error entry at 30 fraction bits
    localparam int ESPL = 19;  // split point of the error for the gain product
    localparam int SUMW = 58;

    typedef enum logic [2:0] {
        CFG_TARGET_QW  = 3'd0,
        CFG_TARGET_QX  = 3'd1,
        CFG_TARGET_QY  = 3'd2,
        CFG_TARGET_QZ  = 3'd3,
        CFG_GAIN_ROLL  = 3'd4,
        CFG_GAIN_PITCH = 3'd5,
        CFG_GAIN_YAW   = 3'd6,
        CFG_AXIS_EN    = 3'd7
    } t_cfg_idx;

    // row and column of the error entries (1,2), (2,0), (0,1)
    localparam int ERR_ROW [3] = '{1, 2, 0};
    localparam int ERR_COL [3] = '{2, 0, 1};

endpackage

// File: design/arpc_q2m.sv
// ----------------------------------------------------------------------------
// arpc_q2m
// quaternion to rotation matrix, three register stages
// ----------------------------------------------------------------------------
module arpc_q2m
    import arpc_pkg::*;
#(
    parameter int QW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [QW-1:0] i_q [4],
    output logic signed [MW-1:0] o_m [9]
);

    logic signed [Q15W-1:0] n_q [4];
    logic signed [Q15W-1:0] r_q [4];
    logic signed [PW-1:0]   n_p [9];
    logic signed [PW-1:0]   r_p [9];
    logic signed [TW-1:0]   t   [9];
    logic signed [MW-1:0]   n_m [9];
    logic signed [MW-1:0]   r_m [9];

    for (genvar g = 0; g < 4; g++) begin : g_q15
        if (QW > 16) begin : g_rnd
            logic signed [QW:0] w;
            assign w = $signed({i_q[g][QW-1], i_q[g]})
                     + $signed((QW+1)'(1) << (QW - 17));
            assign n_q[g] = Q15W'(w >>> (QW - 16));
        end else begin : g_shl
            assign n_q[g] = Q15W'(i_q[g]) <<< (16 - QW);
        end
    end

    // products xx yy zz xy xz yz wx wy wz
    always_comb begin
        n_p[0] = r_q[1] * r_q[1];
        n_p[1] = r_q[2] * r_q[2];
        n_p[2] = r_q[3] * r_q[3];
        n_p[3] = r_q[1] * r_q[2];
        n_p[4] = r_q[1] * r_q[3];
        n_p[5] = r_q[2] * r_q[3];
        n_p[6] = r_q[0] * r_q[1];
        n_p[7] = r_q[0] * r_q[2];
        n_p[8] = r_q[0] * r_q[3];
    end

    always_comb begin
        t[0] = (TW'(1) <<< 30) - ((TW'(r_p[1]) + TW'(r_p[2])) <<< 1);
        t[1] = (TW'(r_p[3]) - TW'(r_p[8])) <<< 1;
        t[2] = (TW'(r_p[4]) + TW'(r_p[7])) <<< 1;
        t[3] = (TW'(r_p[3]) + TW'(r_p[8])) <<< 1;
        t[4] = (TW'(1) <<< 30) - ((TW'(r_p[0]) + TW'(r_p[2])) <<< 1);
        t[5] = (TW'(r_p[5]) - TW'(r_p[6])) <<< 1;
        t[6] = (TW'(r_p[4]) - TW'(r_p[7])) <<< 1;
        t[7] = (TW'(r_p[5]) + TW'(r_p[6])) <<< 1;
        t[8] = (TW'(1) <<< 30) - ((TW'(r_p[0]) + TW'(r_p[1])) <<< 1);
        for (int k = 0; k < 9; k++) begin
            n_m[k] = MW'((t[k] + (TW'(1) <<< 14)) >>> 15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
            r_p <= n_p;
            r_m <= n_m;
        end
    end

    assign o_m = r_m;

endmodule

// File: design/arpc_err.sv
// ----------------------------------------------------------------------------
// arpc_err
// skew error entries and body-frame feedforward, two register stages
// ----------------------------------------------------------------------------
module arpc_err
    import arpc_pkg::*;
#(
    parameter int RW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [MW-1:0] i_r [9],
    input  logic signed [MW-1:0] i_d [9],
    input  logic signed [RW-1:0] i_v [3],
    output logic signed [EW-1:0] o_e [3],
    output logic signed [RW+5:0] o_ff [3]
);

    localparam int FPW = MW + RW;
    localparam int FSW = FPW + 2;

    logic signed [EPW-1:0] n_pe  [3][6];
    logic signed [EPW-1:0] r_pe  [3][6];
    logic signed [FPW-1:0] n_pf  [3][3];
    logic signed [FPW-1:0] r_pf  [3][3];
    logic signed [EW-1:0]  n_e   [3];
    logic signed [EW-1:0]  r_e   [3];
    logic signed [FSW-1:0] fsum  [3];
    logic signed [RW+5:0]  n_ff  [3];
    logic signed [RW+5:0]  r_ff  [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
                n_pe[a][2*k]   = i_d[3*k + ERR_ROW[a]] * i_r[3*k + ERR_COL[a]];
                n_pe[a][2*k+1] = i_r[3*k + ERR_ROW[a]] * i_d[3*k + ERR_COL[a]];
                n_pf[a][k]     = FPW'(i_r[3*k + a]) * FPW'(i_v[k]);
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_e[a] = EW'(r_pe[a][0]) - EW'(r_pe[a][1])
                   + EW'(r_pe[a][2]) - EW'(r_pe[a][3])
                   + EW'(r_pe[a][4]) - EW'(r_pe[a][5]);
            fsum[a] = FSW'(r_pf[a][0]) + FSW'(r_pf[a][1]) + FSW'(r_pf[a][2]);
            n_ff[a] = (RW+6)'((fsum[a] + (FSW'(1) <<< 14)) >>> 15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pe <= n_pe;
            r_pf <= n_pf;
            r_e  <= n_e;
            r_ff <= n_ff;
        end
    end

    assign o_e  = r_e;
    assign o_ff = r_ff;

endmodule

// File: design/arpc_out.sv
// ----------------------------------------------------------------------------
// arpc_out
// gain, axis gating, feedforward add and saturation, two register stages
// ----------------------------------------------------------------------------
module arpc_out
    import arpc_pkg::*;
#(
    parameter int RW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic signed [EW-1:0] i_e [3],
    input  logic signed [RW+5:0] i_ff [3],
    input  logic        [15:0]   i_gain [3],
    input  logic        [2:0]    i_mask,
    output logic signed [RW-1:0] o_cmd [3],
    output logic                 o_sat
);

    localparam int SH  = 43 - RW;
    localparam int LOW = ESPL + 18;
    localparam int HIW = EW - ESPL + 17;

    logic        [15:0]    g     [3];
    logic signed [LOW-1:0] n_lo  [3];
    logic signed [LOW-1:0] r_lo  [3];
    logic signed [HIW-1:0] n_hi  [3];
    logic signed [HIW-1:0] r_hi  [3];
    logic signed [RW+5:0]  r_ff  [3];
    logic signed [SUMW-1:0] prod [3];
    logic signed [SUMW-1:0] sum  [3];
    logic signed [RW-1:0]  n_cmd [3];
    logic signed [RW-1:0]  r_cmd [3];
    logic                  n_sat;
    logic                  r_sat;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            g[a]    = i_mask[a] ? i_gain[a] : 16'd0;
            n_lo[a] = LOW'($signed({1'b0, i_e[a][ESPL-1:0]}) * $signed({1'b0, g[a]}));
            n_hi[a] = HIW'($signed(i_e[a][EW-1:ESPL]) * $signed({1'b0, g[a]}));
        end
    end

    always_comb begin
        n_sat = 1'b0;
        for (int a = 0; a < 3; a++) begin
            prod[a] = (SUMW'(r_hi[a]) <<< ESPL) + SUMW'(r_lo[a]);
            sum[a]  = ((prod[a] + (SUMW'(1) <<< (SH - 1))) >>> SH) + SUMW'(r_ff[a]);
            if (sum[a] > ((SUMW'(1) <<< (RW - 1)) - SUMW'(1))) begin
                n_cmd[a] = {1'b0, {(RW-1){1'b1}}};
                n_sat    = 1'b1;
            end else if (sum[a] < -(SUMW'(1) <<< (RW - 1))) begin
                n_cmd[a] = {1'b1, {(RW-1){1'b0}}};
                n_sat    = 1'b1;
            end else begin
                n_cmd[a] = RW'(sum[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_ff  <= i_ff;
            r_cmd <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_en) begin
            r_sat <= n_sat;
        end
    end

    assign o_cmd = r_cmd;
    assign o_sat = r_sat;

endmodule

// File: design/attitude_rotation_error_p_control.sv
// ----------------------------------------------------------------------------
// attitude_rotation_error_p_control
// attitude p controller on rotation matrices with body-rate feedforward
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle while the output side is not stalled, and
// delivers its result through the output register; a stall on the output
// side holds the whole seven-stage pipeline in place. The target quaternion,
// gains and axis mask are written over the config channel, which is always
// ready; write them only while no beat is in flight.
module attitude_rotation_error_p_control
    import arpc_pkg::*;
#(
    parameter int QUAT_WIDTH = 16,
    parameter int RATE_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // meas_qw, meas_qx, meas_qy, meas_qz, ff_rate_x, ff_rate_y, ff_rate_z
    input  logic [((4*QUAT_WIDTH + 3*RATE_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // cmd_rate_x, cmd_rate_y, cmd_rate_z
    output logic [((3*RATE_WIDTH + 7) / 8) * 8 - 1:0] o_m_tdata,
    // saturated
    output logic o_m_tuser,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [((QUAT_WIDTH > 16) ? QUAT_WIDTH : 16) - 1:0] i_cfg_data
);

    localparam int QW    = QUAT_WIDTH;
    localparam int RW    = RATE_WIDTH;
    localparam int OUTW  = ((3*RW + 7) / 8) * 8;
    localparam int NSTG  = 7;

    logic signed [QW-1:0] r_tq [4];
    logic        [15:0]   r_gain [3];
    logic        [2:0]    r_mask;
    logic        [NSTG-1:0] r_vld;
    logic                 en;

    logic signed [QW-1:0] mq [4];
    logic signed [RW-1:0] v  [3];
    logic signed [RW-1:0] r_v [3][3];
    logic signed [MW-1:0] rm [9];
    logic signed [MW-1:0] dm [9];
    logic signed [EW-1:0] e  [3];
    logic signed [RW+5:0] ff [3];
    logic signed [RW-1:0] cmd [3];
    logic                 sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tq[0] <= QW'(32767);
            r_tq[1] <= '0;
            r_tq[2] <= '0;
            r_tq[3] <= '0;
            r_gain  <= '{16'd256, 16'd256, 16'd256};
            r_mask  <= 3'd7;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_QW:  r_tq[0]   <= i_cfg_data[QW-1:0];
                CFG_TARGET_QX:  r_tq[1]   <= i_cfg_data[QW-1:0];
                CFG_TARGET_QY:  r_tq[2]   <= i_cfg_data[QW-1:0];
                CFG_TARGET_QZ:  r_tq[3]   <= i_cfg_data[QW-1:0];
                CFG_GAIN_ROLL:  r_gain[0] <= i_cfg_data[15:0];
                CFG_GAIN_PITCH: r_gain[1] <= i_cfg_data[15:0];
                CFG_GAIN_YAW:   r_gain[2] <= i_cfg_data[15:0];
                CFG_AXIS_EN:    r_mask    <= i_cfg_data[2:0];
                default:        r_mask    <= r_mask;
            endcase
        end
    end

    assign en         = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid};
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_mq
        assign mq[g] = i_s_tdata[g*QW +: QW];
    end
    for (genvar g = 0; g < 3; g++) begin : g_v
        assign v[g] = i_s_tdata[4*QW + g*RW +: RW];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v[0] <= v;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
        end
    end

    arpc_q2m #(.QW(QW)) u_meas (
        .i_clk (i_clk),
        .i_en  (en),
        .i_q   (mq),
        .o_m   (rm)
    );

    arpc_q2m #(.QW(QW)) u_target (
        .i_clk (i_clk),
        .i_en  (en),
        .i_q   (r_tq),
        .o_m   (dm)
    );

    arpc_err #(.RW(RW)) u_err (
        .i_clk (i_clk),
        .i_en  (en),
        .i_r   (rm),
        .i_d   (dm),
        .i_v   (r_v[2]),
        .o_e   (e),
        .o_ff  (ff)
    );

    arpc_out #(.RW(RW)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_e     (e),
        .i_ff    (ff),
        .i_gain  (r_gain),
        .i_mask  (r_mask),
        .o_cmd   (cmd),
        .o_sat   (sat)
    );

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = OUTW'({cmd[2], cmd[1], cmd[0]});
    assign o_m_tuser  = sat;

endmodule
